FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is high
`define TTWAG_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// assertion that is checked during reset as well
`define TTWAG_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

FILE: rtl/ttwag_pkg.sv
// ----------------------------------------------------------------------------
// ttwag_pkg
// Types, constants and helper functions for the tiled texture address walk.
// ----------------------------------------------------------------------------
package ttwag_pkg;

   // default size limits, handed to the top level parameters
   localparam int MAX_TILES_ACROSS_DEF = 64;
   localparam int MAX_TILES_DOWN_DEF   = 64;

   // register field widths
   localparam int TILE_COUNT_W = 7;
   localparam int STRIDE_W     = 20;
   localparam int ADDR_W       = 32;
   localparam int OFFSET_W     = 30;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 4;

   // register reset values
   localparam logic [TILE_COUNT_W-1:0] TILES_ACROSS_RST = 7'd8;
   localparam logic [TILE_COUNT_W-1:0] TILES_DOWN_RST   = 7'd8;
   localparam logic [STRIDE_W-1:0]     STRIDE_RST       = 20'd1024;
   localparam logic [ADDR_W-1:0]       BASE_RST         = 32'd0;

   // word index inside one tile: sub-tile, micro row, micro col, row, word
   localparam int WORD_IDX_W = 10;
   localparam logic [WORD_IDX_W-1:0] WORD_IDX_LAST = 10'd1023;

   // register map, one 32-bit word each
   typedef enum logic [1:0] {
      CSR_TILES_ACROSS = 2'd0,
      CSR_TILES_DOWN   = 2'd1,
      CSR_ROW_STRIDE   = 2'd2,
      CSR_BASE_ADDRESS = 2'd3
   } csr_index_type;

   // position inside a tile, plus the end-of-image mark
   typedef struct packed {
      logic       sub_x;
      logic       sub_y;
      logic [1:0] micro_row;
      logic [1:0] row_in_micro;
      logic [1:0] micro_col;
      logic [1:0] word_in_row;
      logic       last;
   } pos_fine_type;

   // sub-tile x half: even rows 0,0,1,1 / odd rows 1,1,0,0
   function automatic logic sub_x_of(input logic odd, input logic [1:0] sub);
      sub_x_of = odd ^ sub[1];
   endfunction

   // sub-tile y half: even rows 0,1,1,0 / odd rows 1,0,0,1
   function automatic logic sub_y_of(input logic odd, input logic [1:0] sub);
      sub_y_of = odd ^ sub[1] ^ sub[0];
   endfunction

endpackage

FILE: rtl/tiled_texture_word_address_generator.sv
// ----------------------------------------------------------------------------
// tiled_texture_word_address_generator
// Word offsets of a linear 32bpp bitmap in tiled texture order: 32x32 tiles
// walked serpentine, 16x16 sub-tiles, 4x4-word micro-tiles.
//
//   channel  direction  handshake          payload
//   req      in         valid / stall      restart
//   rsp      out        valid / stall      word_offset, last_word
//   csr      in/out     APB-style write    4 registers, 32 bits each
//
// One transaction per cycle, sustained while the result side does not stall.
// A request transaction passes the walk stage, then the multiply-add stage
// (pixel row times stride plus base) into the result register. Reset clears
// the walk and both stage valids and loads register defaults. A stalled
// result holds; the walk stage keeps taking requests until it also holds an
// item.
// ----------------------------------------------------------------------------
module tiled_texture_word_address_generator #(
   parameter int MAX_TILES_ACROSS = ttwag_pkg::MAX_TILES_ACROSS_DEF,
   parameter int MAX_TILES_DOWN   = ttwag_pkg::MAX_TILES_DOWN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   // result
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ttwag_pkg::OFFSET_W-1:0]     rsp_word_offset,
   output logic                               rsp_last_word,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ttwag_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ttwag_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ttwag_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);

   localparam int RowW = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;
   localparam int ColW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;

   logic [ttwag_pkg::TILE_COUNT_W-1:0] tiles_across;
   logic [ttwag_pkg::TILE_COUNT_W-1:0] tiles_down;
   logic [ttwag_pkg::STRIDE_W-1:0]     row_stride_bytes;
   logic [ttwag_pkg::ADDR_W-1:0]       base_address;
   logic                               stage_free;
   logic                               stage_valid;
   logic [RowW-1:0]                    stage_row;
   logic [ColW-1:0]                    stage_col;
   ttwag_pkg::pos_fine_type            stage_fine;

   // configuration registers
   ttwag_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .tiles_across     (tiles_across),
      .tiles_down       (tiles_down),
      .row_stride_bytes (row_stride_bytes),
      .base_address     (base_address)
   );

   // position walk
   ttwag_walk #(
      .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
      .MAX_TILES_DOWN   (MAX_TILES_DOWN),
      .RowW             (RowW),
      .ColW             (ColW)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_restart  (req_restart),
      .req_stall    (req_stall),
      .tiles_across (tiles_across),
      .tiles_down   (tiles_down),
      .stage_free   (stage_free),
      .stage_valid  (stage_valid),
      .stage_row    (stage_row),
      .stage_col    (stage_col),
      .stage_fine   (stage_fine)
   );

   // address and result register
   ttwag_addr #(
      .RowW (RowW),
      .ColW (ColW)
   ) u_addr (
      .clock            (clock),
      .reset            (reset),
      .stage_valid      (stage_valid),
      .stage_row        (stage_row),
      .stage_col        (stage_col),
      .stage_fine       (stage_fine),
      .row_stride_bytes (row_stride_bytes),
      .base_address     (base_address),
      .stage_free       (stage_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_offset  (rsp_word_offset),
      .rsp_last_word    (rsp_last_word)
   );

endmodule

FILE: rtl/ttwag_csr.sv
// ----------------------------------------------------------------------------
// ttwag_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module ttwag_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ttwag_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ttwag_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ttwag_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready,
   output logic [ttwag_pkg::TILE_COUNT_W-1:0]   tiles_across,
   output logic [ttwag_pkg::TILE_COUNT_W-1:0]   tiles_down,
   output logic [ttwag_pkg::STRIDE_W-1:0]       row_stride_bytes,
   output logic [ttwag_pkg::ADDR_W-1:0]         base_address
);

   logic [ttwag_pkg::TILE_COUNT_W-1:0] tiles_across_ff, tiles_across_in;
   logic [ttwag_pkg::TILE_COUNT_W-1:0] tiles_down_ff, tiles_down_in;
   logic [ttwag_pkg::STRIDE_W-1:0]     stride_ff, stride_in;
   logic [ttwag_pkg::ADDR_W-1:0]       base_ff, base_in;
   logic                               wr_en;
   ttwag_pkg::csr_index_type           index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign index      = ttwag_pkg::csr_index_type'(csr_paddr[3:2]);

   // write decode
   always_comb begin
      tiles_across_in = tiles_across_ff;
      tiles_down_in   = tiles_down_ff;
      stride_in       = stride_ff;
      base_in         = base_ff;
      if (wr_en) begin
         case (index)
            ttwag_pkg::CSR_TILES_ACROSS: begin
               tiles_across_in = csr_pwdata[ttwag_pkg::TILE_COUNT_W-1:0];
            end
            ttwag_pkg::CSR_TILES_DOWN: begin
               tiles_down_in = csr_pwdata[ttwag_pkg::TILE_COUNT_W-1:0];
            end
            ttwag_pkg::CSR_ROW_STRIDE: begin
               stride_in = csr_pwdata[ttwag_pkg::STRIDE_W-1:0];
            end
            ttwag_pkg::CSR_BASE_ADDRESS: begin
               base_in = csr_pwdata[ttwag_pkg::ADDR_W-1:0];
            end
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_across_ff <= ttwag_pkg::TILES_ACROSS_RST;
         tiles_down_ff   <= ttwag_pkg::TILES_DOWN_RST;
         stride_ff       <= ttwag_pkg::STRIDE_RST;
         base_ff         <= ttwag_pkg::BASE_RST;
      end else begin
         tiles_across_ff <= tiles_across_in;
         tiles_down_ff   <= tiles_down_in;
         stride_ff       <= stride_in;
         base_ff         <= base_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         ttwag_pkg::CSR_TILES_ACROSS: csr_prdata = 32'(tiles_across_ff);
         ttwag_pkg::CSR_TILES_DOWN:   csr_prdata = 32'(tiles_down_ff);
         ttwag_pkg::CSR_ROW_STRIDE:   csr_prdata = 32'(stride_ff);
         ttwag_pkg::CSR_BASE_ADDRESS: csr_prdata = base_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   assign tiles_across     = tiles_across_ff;
   assign tiles_down       = tiles_down_ff;
   assign row_stride_bytes = stride_ff;
   assign base_address     = base_ff;

endmodule

FILE: rtl/ttwag_walk.sv
// ----------------------------------------------------------------------------
// ttwag_walk
// Walk position counters and the input stage register. Each accepted
// transaction takes the current position into the stage and advances it, unless the image is empty.
// ----------------------------------------------------------------------------
module ttwag_walk #(
   parameter int MAX_TILES_ACROSS = ttwag_pkg::MAX_TILES_ACROSS_DEF,
   parameter int MAX_TILES_DOWN   = ttwag_pkg::MAX_TILES_DOWN_DEF,
   parameter int RowW = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1,
   parameter int ColW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_restart,
   output logic                               req_stall,
   input  logic [ttwag_pkg::TILE_COUNT_W-1:0] tiles_across,
   input  logic [ttwag_pkg::TILE_COUNT_W-1:0] tiles_down,
   input  logic                               stage_free,
   output logic                               stage_valid,
   output logic [RowW-1:0]                    stage_row,
   output logic [ColW-1:0]                    stage_col,
   output ttwag_pkg::pos_fine_type            stage_fine
);

   localparam int AcW = $clog2(MAX_TILES_ACROSS + 1);
   localparam int DnW = $clog2(MAX_TILES_DOWN + 1);

   logic [RowW-1:0]                 row_ff, row_in;
   logic [ColW-1:0]                 step_ff, step_in;
   logic [ttwag_pkg::WORD_IDX_W-1:0] word_ff, word_in;

   logic                            valid_ff, valid_in;
   logic [RowW-1:0]                 srow_ff, srow_in;
   logic [ColW-1:0]                 scol_ff, scol_in;
   ttwag_pkg::pos_fine_type         sfine_ff, sfine_in;

   logic [AcW-1:0]                  across;
   logic [DnW-1:0]                  down;
   logic                            accept, empty, stale, odd;
   logic [RowW-1:0]                 row0, row1;
   logic [ColW-1:0]                 step0, step1;
   logic [ttwag_pkg::WORD_IDX_W-1:0] word0, word1;
   logic [1:0]                      sub;

   // tile counts saturate at the configured maximum
   assign across = (32'(tiles_across) > 32'(MAX_TILES_ACROSS)) ?
                   AcW'(MAX_TILES_ACROSS) : AcW'(tiles_across);
   assign down   = (32'(tiles_down) > 32'(MAX_TILES_DOWN)) ?
                   DnW'(MAX_TILES_DOWN) : DnW'(tiles_down);

   assign req_stall = valid_ff && !stage_free;
   assign accept    = req_valid && !req_stall;
   assign empty     = (across == '0) || (down == '0);

   // restart, then rewind a position left outside the image
   always_comb begin
      row0  = req_restart ? '0 : row_ff;
      step0 = req_restart ? '0 : step_ff;
      word0 = req_restart ? '0 : word_ff;
      stale = (DnW'(row0) >= down) || (AcW'(step0) >= across);
      row1  = stale ? '0 : row0;
      step1 = stale ? '0 : step0;
      word1 = stale ? '0 : word0;
   end

   // serpentine column and sub-tile order
   assign odd = row1[0];
   assign sub = word1[9:8];

   always_comb begin
      srow_in = row1;
      scol_in = odd ? ColW'(across - AcW'(1) - AcW'(step1)) : step1;
      sfine_in.sub_x        = ttwag_pkg::sub_x_of(odd, sub);
      sfine_in.sub_y        = ttwag_pkg::sub_y_of(odd, sub);
      sfine_in.micro_row    = word1[7:6];
      sfine_in.micro_col    = word1[5:4];
      sfine_in.row_in_micro = word1[3:2];
      sfine_in.word_in_row  = word1[1:0];
      sfine_in.last = (DnW'(row1) == down - DnW'(1)) &&
                      (AcW'(step1) == across - AcW'(1)) &&
                      (word1 == ttwag_pkg::WORD_IDX_LAST);
   end

   // next position
   always_comb begin
      row_in  = row_ff;
      step_in = step_ff;
      word_in = word_ff;
      if (accept) begin
         if (empty) begin
            row_in  = row0;
            step_in = step0;
            word_in = word0;
         end else if (word1 != ttwag_pkg::WORD_IDX_LAST) begin
            row_in  = row1;
            step_in = step1;
            word_in = word1 + 10'd1;
         end else begin
            word_in = '0;
            if ((AcW'(step1) + AcW'(1)) < across) begin
               row_in  = row1;
               step_in = step1 + ColW'(1);
            end else begin
               step_in = '0;
               row_in  = ((DnW'(row1) + DnW'(1)) < down) ? row1 + RowW'(1) : '0;
            end
         end
      end
   end

   // stage valid: filled by a transaction, drained into the result stage
   always_comb begin
      if (accept && !empty) begin
         valid_in = 1'b1;
      end else if (stage_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         step_ff  <= '0;
         word_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         step_ff  <= step_in;
         word_ff  <= word_in;
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept && !empty) begin
         srow_ff  <= srow_in;
         scol_ff  <= scol_in;
         sfine_ff <= sfine_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_row   = srow_ff;
   assign stage_col   = scol_ff;
   assign stage_fine  = sfine_ff;

endmodule

FILE: rtl/ttwag_addr.sv
// ----------------------------------------------------------------------------
// ttwag_addr
// Byte address from the tiled position, divided by four, into the result
// register.
// ----------------------------------------------------------------------------
module ttwag_addr #(
   parameter int RowW = 6,
   parameter int ColW = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                stage_valid,
   input  logic [RowW-1:0]                     stage_row,
   input  logic [ColW-1:0]                     stage_col,
   input  ttwag_pkg::pos_fine_type             stage_fine,
   input  logic [ttwag_pkg::STRIDE_W-1:0]      row_stride_bytes,
   input  logic [ttwag_pkg::ADDR_W-1:0]        base_address,
   output logic                                stage_free,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ttwag_pkg::OFFSET_W-1:0]      rsp_word_offset,
   output logic                                rsp_last_word
);

   localparam int PixRowW = RowW + 5;
   localparam int ProdW   = PixRowW + ttwag_pkg::STRIDE_W;
   localparam int InRowW  = ColW + 7;

   logic                               valid_ff, valid_in;
   logic [ttwag_pkg::OFFSET_W-1:0]     offset_ff;
   logic                               last_ff;
   logic [PixRowW-1:0]                 pix_row;
   logic [ProdW-1:0]                   row_bytes;
   logic [InRowW-1:0]                  in_row_bytes;
   logic [ttwag_pkg::ADDR_W-1:0]       byte_addr;

   // result register takes a new transaction when empty or being drained
   assign stage_free = !valid_ff || !rsp_stall;

   // pixel row = tile row*32 + sub y*16 + micro row*4 + row in micro
   assign pix_row = {stage_row, stage_fine.sub_y, stage_fine.micro_row,
                     stage_fine.row_in_micro};
   assign row_bytes = ProdW'(pix_row) * ProdW'(row_stride_bytes);

   // bytes into the row = col*128 + sub x*64 + micro col*16 + word*4
   assign in_row_bytes = {stage_col, stage_fine.sub_x, stage_fine.micro_col,
                          stage_fine.word_in_row, 2'b00};

   assign byte_addr = base_address + 32'(row_bytes) + 32'(in_row_bytes);

   always_comb begin
      if (stage_free) begin
         valid_in = stage_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_free && stage_valid) begin
         offset_ff <= byte_addr[ttwag_pkg::ADDR_W-1:2];
         last_ff   <= stage_fine.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_word_offset = offset_ff;
   assign rsp_last_word   = last_ff;

endmodule

FILE: rtl/ttwag_checker.sv
// ----------------------------------------------------------------------------
// ttwag_checker
// Port-level checks for the tiled texture address generator, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttwag_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [ttwag_pkg::OFFSET_W-1:0]     rsp_word_offset,
   input logic                               rsp_last_word
);

   // no result is pending right after reset
   `TTWAG_ASSERT_ALWAYS(a_rst_clears, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

   // a new result follows an earlier request transaction
   `TTWAG_ASSERT(a_rsp_from_req, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2), "result without request")

   // a stalled result stays offered
   `TTWAG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped under stall")

   // a stalled result keeps its payload
   `TTWAG_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_word_offset) && $stable(rsp_last_word), "result changed under stall")

endmodule

bind tiled_texture_word_address_generator ttwag_checker u_checker (.*);

FILE: verif/tiled_address_checker.sv
// ----------------------------------------------------------------------------
// tiled_address_checker
// Watches the request, result and register ports of the tiled texture address
// generator, predicts every word offset and end-of-image mark, and compares
// each result transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tiled_address_checker #(
   parameter int MAX_TILES_ACROSS = ttwag_pkg::MAX_TILES_ACROSS_DEF,
   parameter int MAX_TILES_DOWN   = ttwag_pkg::MAX_TILES_DOWN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_restart,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [ttwag_pkg::OFFSET_W-1:0]     rsp_word_offset,
   input  logic                               rsp_last_word,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic                               csr_pready,
   input  logic [ttwag_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ttwag_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output int unsigned                        words_outstanding,
   output int unsigned                        mismatch_count
);

   // tile geometry, 32 bits per pixel
   localparam int unsigned TILE_PX        = 32;
   localparam int unsigned SUB_PX         = 16;
   localparam int unsigned MICRO_ROWS     = 4;
   localparam int unsigned TILE_BYTES     = 128;
   localparam int unsigned SUB_BYTES      = 64;
   localparam int unsigned MICRO_BYTES    = 16;
   localparam int unsigned WORD_BYTES     = 4;
   localparam int unsigned WORDS_PER_TILE = 1024;

   // sub-tile half offsets per slot, bit i is slot i
   localparam logic [3:0] SUB_X_EVEN = 4'b1100;
   localparam logic [3:0] SUB_Y_EVEN = 4'b0110;
   localparam logic [3:0] SUB_X_ODD  = 4'b0011;
   localparam logic [3:0] SUB_Y_ODD  = 4'b1001;

   typedef struct packed {
      logic [ttwag_pkg::OFFSET_W-1:0] word_offset;
      logic                           last_word;
   } tiled_word_type;

   // register copies
   logic [ttwag_pkg::TILE_COUNT_W-1:0] cfg_across;
   logic [ttwag_pkg::TILE_COUNT_W-1:0] cfg_down;
   logic [ttwag_pkg::STRIDE_W-1:0]     cfg_stride;
   logic [ttwag_pkg::ADDR_W-1:0]       cfg_base;

   // walk position
   int unsigned walk_row;
   int unsigned walk_step;
   int unsigned walk_word;

   tiled_word_type pending_words[$];

   function automatic void rewind_to_origin();
      walk_row  = 0;
      walk_step = 0;
      walk_word = 0;
   endfunction

   // next word of the walk; returns 0 when the image is empty
   function automatic bit predict_word(input logic restart, output tiled_word_type word);
      int unsigned across, down, col, prow;
      int unsigned kw, trow, mcol, mrow, sub;
      logic        odd, sx, sy;
      logic [31:0] byte_addr;
      word   = '0;
      across = (cfg_across > MAX_TILES_ACROSS) ? MAX_TILES_ACROSS : cfg_across;
      down   = (cfg_down > MAX_TILES_DOWN) ? MAX_TILES_DOWN : cfg_down;
      if (restart) rewind_to_origin();
      if (across == 0 || down == 0) return 1'b0;
      // position left outside a resized image starts over
      if (walk_row >= down || walk_step >= across || walk_word >= WORDS_PER_TILE)
         rewind_to_origin();

      kw   = walk_word & 3;
      trow = (walk_word >> 2) & 3;
      mcol = (walk_word >> 4) & 3;
      mrow = (walk_word >> 6) & 3;
      sub  = (walk_word >> 8) & 3;

      // serpentine: odd tile rows run right to left with rotated sub-tiles
      odd = walk_row[0];
      col = odd ? (across - 1 - walk_step) : walk_step;
      sx  = odd ? SUB_X_ODD[sub] : SUB_X_EVEN[sub];
      sy  = odd ? SUB_Y_ODD[sub] : SUB_Y_EVEN[sub];

      prow = walk_row * TILE_PX + sy * SUB_PX + mrow * MICRO_ROWS + trow;
      byte_addr = cfg_base + prow * cfg_stride + col * TILE_BYTES + sx * SUB_BYTES
                + mcol * MICRO_BYTES + kw * WORD_BYTES;

      word.word_offset = byte_addr[31:2];
      word.last_word   = (walk_row == down - 1) && (walk_step == across - 1)
                      && (walk_word == WORDS_PER_TILE - 1);

      // advance, wrapping at the end of the image
      if (walk_word + 1 < WORDS_PER_TILE) begin
         walk_word = walk_word + 1;
      end else begin
         walk_word = 0;
         if (walk_step + 1 < across) begin
            walk_step = walk_step + 1;
         end else begin
            walk_step = 0;
            walk_row  = (walk_row + 1 < down) ? walk_row + 1 : 0;
         end
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      tiled_word_type           predicted;
      tiled_word_type           observed;
      int unsigned              fresh_errors;
      ttwag_pkg::csr_index_type reg_index;
      fresh_errors = 0;
      if (reset) begin
         cfg_across = ttwag_pkg::TILES_ACROSS_RST;
         cfg_down   = ttwag_pkg::TILES_DOWN_RST;
         cfg_stride = ttwag_pkg::STRIDE_RST;
         cfg_base   = ttwag_pkg::BASE_RST;
         rewind_to_origin();
         pending_words.delete();
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            reg_index = ttwag_pkg::csr_index_type'(csr_paddr[3:2]);
            case (reg_index)
               ttwag_pkg::CSR_TILES_ACROSS:
                  cfg_across = csr_pwdata[ttwag_pkg::TILE_COUNT_W-1:0];
               ttwag_pkg::CSR_TILES_DOWN:
                  cfg_down   = csr_pwdata[ttwag_pkg::TILE_COUNT_W-1:0];
               ttwag_pkg::CSR_ROW_STRIDE:
                  cfg_stride = csr_pwdata[ttwag_pkg::STRIDE_W-1:0];
               ttwag_pkg::CSR_BASE_ADDRESS:
                  cfg_base   = csr_pwdata[ttwag_pkg::ADDR_W-1:0];
               default: ;
            endcase
         end

         // request transaction
         if (req_valid && !req_stall) begin
            if (predict_word(req_restart, predicted)) pending_words.push_back(predicted);
         end

         // result transaction
         if (rsp_valid && !rsp_stall) begin
            observed.word_offset = rsp_word_offset;
            observed.last_word   = rsp_last_word;
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected result word_offset %h last_word %b",
                        $time, observed.word_offset, observed.last_word);
               fresh_errors++;
            end else begin
               predicted = pending_words.pop_front();
               if (observed.word_offset !== predicted.word_offset) begin
                  $display("%0t: word_offset expected %h actual %h",
                           $time, predicted.word_offset, observed.word_offset);
                  fresh_errors++;
               end
               if (observed.last_word !== predicted.last_word) begin
                  $display("%0t: last_word expected %b actual %b (offset %h)",
                           $time, predicted.last_word, observed.last_word,
                           predicted.word_offset);
                  fresh_errors++;
               end
            end
         end
      end
      words_outstanding <= pending_words.size();
      mismatch_count    <= mismatch_count + fresh_errors;
   end

endmodule

FILE: verif/tb_tiled_texture_word_address_generator.sv
// ----------------------------------------------------------------------------
// tb_tiled_texture_word_address_generator
// Drives restart requests and register writes into the tiled texture address
// generator under several idle and stall mixes; a separate checker predicts
// and compares every result, and this top reports the verdict.
// ----------------------------------------------------------------------------
module tb_tiled_texture_word_address_generator;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;

   logic                                clock;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   logic                                req_restart = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   logic [ttwag_pkg::OFFSET_W-1:0]      rsp_word_offset;
   logic                                rsp_last_word;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [ttwag_pkg::CSR_ADDR_W-1:0]    csr_paddr   = '0;
   logic [ttwag_pkg::CSR_DATA_W-1:0]    csr_pwdata  = '0;
   logic [ttwag_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                                csr_pready;

   int unsigned words_outstanding;
   int unsigned mismatch_count;
   int unsigned cycle_count = 0;
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct = 0;

   tiled_texture_word_address_generator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word_offset (rsp_word_offset),
      .rsp_last_word   (rsp_last_word),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   tiled_address_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word_offset   (rsp_word_offset),
      .rsp_last_word     (rsp_last_word),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .words_outstanding (words_outstanding),
      .mismatch_count    (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // setup and access cycle of one register write
   task automatic csr_write(input ttwag_pkg::csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // junk above the field width, which the register must drop
   function automatic logic [31:0] pad_upper(input logic [31:0] field, input int field_w);
      return ($urandom() << field_w) | field;
   endfunction

   // one request transaction, with optional idle cycles in front
   task automatic send_word(input logic restart);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_words(input int count, input int unsigned restart_permille);
      repeat (count) send_word($urandom_range(999) < restart_permille);
   endtask

   // wait for every result, then for words of an empty image to flush out
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_count();
      case ($urandom_range(5))
         0: return 0;
         1: return 1;
         2: return 64;
         3: return 127;
         4: return $urandom_range(1, 127);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   function automatic logic [31:0] pick_stride();
      case ($urandom_range(3))
         0: return 0;
         1: return 32'h000F_FFFF;
         default: return $urandom_range(32'h000F_FFFF);
      endcase
   endfunction

   task automatic load_random_setup();
      csr_write(ttwag_pkg::CSR_TILES_ACROSS,
                pad_upper(pick_count(), ttwag_pkg::TILE_COUNT_W));
      csr_write(ttwag_pkg::CSR_TILES_DOWN,
                pad_upper(pick_count(), ttwag_pkg::TILE_COUNT_W));
      csr_write(ttwag_pkg::CSR_ROW_STRIDE,
                pad_upper(pick_stride(), ttwag_pkg::STRIDE_W));
      csr_write(ttwag_pkg::CSR_BASE_ADDRESS, $urandom());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default 8x8 image, restart in the middle of a walk
      send_word(1'b0);
      send_word(1'b0);
      send_word(1'b0);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b0);
      settle();

      // oversize counts saturate, top base address wraps, widest stride
      csr_write(ttwag_pkg::CSR_BASE_ADDRESS, 32'hFFFF_FFFC);
      csr_write(ttwag_pkg::CSR_ROW_STRIDE, 32'hFFFF_FFFF);
      csr_write(ttwag_pkg::CSR_TILES_ACROSS, 32'd127);
      csr_write(ttwag_pkg::CSR_TILES_DOWN, 32'hFFFF_FF80 | 32'd100);
      send_word(1'b1);
      send_words(3, 0);
      settle();

      // empty image: zero tiles across, then zero tiles down
      csr_write(ttwag_pkg::CSR_TILES_ACROSS, 32'd0);
      send_word(1'b0);
      send_word(1'b1);
      send_word(1'b0);
      settle();
      csr_write(ttwag_pkg::CSR_TILES_ACROSS, 32'd1);
      csr_write(ttwag_pkg::CSR_TILES_DOWN, 32'd0);
      send_word(1'b0);
      send_word(1'b1);
      settle();

      // zero stride, zero base
      csr_write(ttwag_pkg::CSR_TILES_DOWN, 32'd64);
      csr_write(ttwag_pkg::CSR_ROW_STRIDE, 32'd0);
      csr_write(ttwag_pkg::CSR_BASE_ADDRESS, 32'd0);
      send_words(3, 0);
      settle();

      // no idling: 1x1 image walked through the last word and the wrap
      csr_write(ttwag_pkg::CSR_TILES_ACROSS, pad_upper(32'd1, ttwag_pkg::TILE_COUNT_W));
      csr_write(ttwag_pkg::CSR_TILES_DOWN, pad_upper(32'd1, ttwag_pkg::TILE_COUNT_W));
      csr_write(ttwag_pkg::CSR_ROW_STRIDE,
                pad_upper($urandom_range(32'h000F_FFFF), ttwag_pkg::STRIDE_W));
      csr_write(ttwag_pkg::CSR_BASE_ADDRESS, $urandom());
      send_word(1'b1);
      send_words(1029, 0);
      settle();

      // sender idles: widen to 2x2 under the walker
      send_gap_pct = 54;
      csr_write(ttwag_pkg::CSR_TILES_ACROSS, pad_upper(32'd2, ttwag_pkg::TILE_COUNT_W));
      csr_write(ttwag_pkg::CSR_TILES_DOWN, pad_upper(32'd2, ttwag_pkg::TILE_COUNT_W));
      csr_write(ttwag_pkg::CSR_BASE_ADDRESS, $urandom());
      send_words(200, 0);
      settle();

      // receiver stalls: one tile across, a few tile rows, restarts mixed in
      send_gap_pct = 0;
      stall_pct    = 54;
      csr_write(ttwag_pkg::CSR_TILES_ACROSS, pad_upper(32'd1, ttwag_pkg::TILE_COUNT_W));
      csr_write(ttwag_pkg::CSR_TILES_DOWN,
                pad_upper($urandom_range(1, 4), ttwag_pkg::TILE_COUNT_W));
      send_words(150, 20);
      settle();

      // both sides idle: random setups with restarts mixed in
      send_gap_pct = 20;
      stall_pct    = 20;
      repeat (8) begin
         load_random_setup();
         send_words(30, 80);
         settle();
      end

      if (mismatch_count == 0 && words_outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
